// File: rtl/core/csh_pkg.sv
// ---------------------------------------------------------------------------
// csh_pkg
// Shared types and constants of the context symbol histogram unit.
// ---------------------------------------------------------------------------
package csh_pkg;

  localparam int unsigned OperationW = 2;
  localparam int unsigned SubspaceW  = 2;
  localparam int unsigned SymbolW    = 8;
  localparam int unsigned ReadBinW   = 16;
  localparam int unsigned CountOutW  = 32;
  // widest counter supported; output saturation works on this width
  localparam int unsigned CountWideW = 48;

  typedef enum logic [OperationW-1:0] {
    OP_COUNT   = 2'd0,
    OP_READ    = 2'd1,
    OP_RESTART = 2'd2
  } csh_op_e;

  // per-request control from the context tracker
  typedef struct packed {
    logic bump;   // increment the addressed counter
    logic rd;     // return the addressed counter
  } csh_ctl_t;

endpackage

// File: rtl/core/csh_count_ram.sv
// ---------------------------------------------------------------------------
// csh_count_ram
// Single-write, single-read synchronous counter store, registered read data.
// ---------------------------------------------------------------------------
module csh_count_ram #(
  parameter int unsigned ADDR_W = 18,
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DEPTH  = 262144
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-before-write on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/csh_context.sv
// ---------------------------------------------------------------------------
// csh_context
// Per-subspace previous-symbol tracking and counter bin selection.
// ---------------------------------------------------------------------------
module csh_context #(
  parameter int unsigned SUBSPACES   = 4,
  parameter int unsigned SYMBOL_BITS = 8,
  parameter int unsigned SUB_W       = 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  csh_pkg::csh_op_e         op_i,
  input  logic [SUB_W-1:0]         sub_idx_i,
  input  logic                     sub_ok_i,
  input  logic [SYMBOL_BITS-1:0]   sym_i,
  input  logic                     context_mode_i,
  output csh_pkg::csh_ctl_t        ctl_o,
  output logic [2*SYMBOL_BITS-1:0] bin_o
);

  logic [SYMBOL_BITS-1:0] last_sym_q [SUBSPACES];
  logic [SUBSPACES-1:0]   ctx_valid_q;
  logic [SYMBOL_BITS-1:0] last_sym;
  logic                   ctx_valid;

  assign last_sym  = sub_ok_i ? last_sym_q[sub_idx_i] : '0;
  assign ctx_valid = sub_ok_i & ctx_valid_q[sub_idx_i];

  always_comb begin
    ctl_o = '0;
    case (op_i)
      csh_pkg::OP_COUNT: ctl_o.bump = sub_ok_i & (~context_mode_i | ctx_valid);
      csh_pkg::OP_READ:  ctl_o.rd   = 1'b1;
      default:           ctl_o      = '0;
    endcase
  end

  assign bin_o = context_mode_i ? {last_sym, sym_i} : {{SYMBOL_BITS{1'b0}}, sym_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_valid_q <= '0;
      for (int i = 0; i < SUBSPACES; i++) begin
        last_sym_q[i] <= '0;
      end
    end else if (accept_i) begin
      case (op_i)
        csh_pkg::OP_COUNT: begin
          // plain mode tracks context too, so a mode switch stays defined
          if (sub_ok_i) begin
            last_sym_q[sub_idx_i]  <= sym_i;
            ctx_valid_q[sub_idx_i] <= 1'b1;
          end
        end
        csh_pkg::OP_RESTART: ctx_valid_q <= '0;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/context_symbol_histogram_unit.sv
// ---------------------------------------------------------------------------
// context_symbol_histogram_unit
// Per-subspace order-1 (order-0 with context mode off) symbol histogram with saturating counters.
// ---------------------------------------------------------------------------
// After reset the unit holds busy high while it zeroes the counter memory
// one entry per cycle, SUBSPACES * 2^(2*SYMBOL_BITS) entries (262144 at the
// defaults); configuration writes are taken during that time. Once
// busy falls, one request is taken every cycle. Each request reads its
// counter at the accepting edge and writes the update back on the next edge;
// back-to-back hits on the same bin are forwarded from the last write, so
// the single-port-write, single-port-read counter memory sets the rate at
// one request per cycle. A read request returns bin_count_o with
// bin_count_valid_o high for one cycle, through stage 1 and the output
// register, in request order. The receiver cannot stall results.
module context_symbol_histogram_unit #(
  parameter int unsigned SUBSPACES   = 4,
  parameter int unsigned SYMBOL_BITS = 8,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [csh_pkg::OperationW-1:0] operation_i,
  input  logic [csh_pkg::SubspaceW-1:0]  subspace_i,
  input  logic [csh_pkg::SymbolW-1:0]    symbol_i,
  input  logic [csh_pkg::ReadBinW-1:0]   read_bin_i,
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,
  output logic                           bin_count_valid_o,
  output logic [csh_pkg::CountOutW-1:0]  bin_count_o
);

  localparam int unsigned SUB_W     = (SUBSPACES > 1) ? $clog2(SUBSPACES) : 1;
  localparam int unsigned SUB_CMP_W = SUB_W + csh_pkg::SubspaceW;
  localparam int unsigned PAIR_BITS = 2 * SYMBOL_BITS;
  localparam int unsigned ADDR_W    = SUB_W + PAIR_BITS;
  localparam int unsigned DEPTH     = SUBSPACES << PAIR_BITS;

  logic                   accept;
  csh_pkg::csh_op_e       op;
  logic [SUB_CMP_W-1:0]   sub_wide;
  logic [SUB_W-1:0]       sub_idx;
  logic                   sub_ok;
  logic [SYMBOL_BITS-1:0] sym;
  logic [PAIR_BITS-1:0]   cnt_bin;
  logic [PAIR_BITS-1:0]   bin;
  csh_pkg::csh_ctl_t      ctl;
  logic                   mode_q;

  logic                   clear_q;
  logic [ADDR_W-1:0]      clr_addr_q;

  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic [COUNT_BITS-1:0]  rd_data;

  logic                   s1_bump_q;
  logic                   s1_rd_q;
  logic                   s1_zero_q;
  logic [ADDR_W-1:0]      s1_addr_q;

  logic                   wr_last_valid_q;
  logic [ADDR_W-1:0]      wr_last_addr_q;
  logic [COUNT_BITS-1:0]  wr_last_data_q;

  logic [COUNT_BITS-1:0]  cur_cnt;
  logic [COUNT_BITS-1:0]  inc_cnt;
  logic [csh_pkg::CountWideW-1:0] cnt_wide;
  logic [csh_pkg::CountOutW-1:0]  cnt_out;

  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [COUNT_BITS-1:0]  mem_wdata;

  logic                   valid_q;
  logic [csh_pkg::CountOutW-1:0] count_q;

  assign busy     = clear_q;
  assign accept   = start & ~clear_q;
  assign op       = csh_pkg::csh_op_e'(operation_i);
  assign sub_wide = {{SUB_W{1'b0}}, subspace_i};
  assign sub_ok   = sub_wide < SUB_CMP_W'(SUBSPACES);
  assign sub_idx  = sub_wide[SUB_W-1:0];
  assign sym      = symbol_i[SYMBOL_BITS-1:0];

  csh_context #(
    .SUBSPACES  (SUBSPACES),
    .SYMBOL_BITS(SYMBOL_BITS),
    .SUB_W      (SUB_W)
  ) u_context (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .op_i          (op),
    .sub_idx_i     (sub_idx),
    .sub_ok_i      (sub_ok),
    .sym_i         (sym),
    .context_mode_i(mode_q),
    .ctl_o         (ctl),
    .bin_o         (cnt_bin)
  );

  assign bin     = ctl.rd ? read_bin_i[PAIR_BITS-1:0] : cnt_bin;
  assign rd_addr = {sub_idx, bin};
  assign rd_en   = accept & sub_ok & (ctl.bump | ctl.rd);

  // last write lands on the same edge as the next read; forward it
  assign cur_cnt = (wr_last_valid_q && (wr_last_addr_q == s1_addr_q)) ?
                   wr_last_data_q : rd_data;
  assign inc_cnt = (&cur_cnt) ? cur_cnt : cur_cnt + COUNT_BITS'(1);

  assign cnt_wide = csh_pkg::CountWideW'(cur_cnt);
  assign cnt_out  = (|cnt_wide[csh_pkg::CountWideW-1:csh_pkg::CountOutW]) ?
                    '1 : cnt_wide[csh_pkg::CountOutW-1:0];

  assign mem_we    = clear_q | s1_bump_q;
  assign mem_waddr = clear_q ? clr_addr_q : s1_addr_q;
  assign mem_wdata = clear_q ? '0 : inc_cnt;

  csh_count_ram #(
    .ADDR_W(ADDR_W),
    .DATA_W(COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q    <= 1'b1;
      clr_addr_q <= '0;
    end else if (clear_q) begin
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        clear_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_bump_q       <= 1'b0;
      s1_rd_q         <= 1'b0;
      wr_last_valid_q <= 1'b0;
      valid_q         <= 1'b0;
    end else begin
      s1_bump_q       <= accept & ctl.bump;
      s1_rd_q         <= accept & ctl.rd;
      wr_last_valid_q <= s1_bump_q;
      valid_q         <= s1_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q      <= rd_addr;
    s1_zero_q      <= ~sub_ok;
    wr_last_addr_q <= s1_addr_q;
    wr_last_data_q <= inc_cnt;
    count_q        <= s1_zero_q ? '0 : cnt_out;
  end

  assign bin_count_valid_o = valid_q;
  assign bin_count_o       = count_q;

`ifndef SYNTHESIS
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_bump_q && s1_rd_q))
    else $error("count and read both active in stage 1");

  a_no_bump_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_q |-> !s1_bump_q && !s1_rd_q)
    else $error("request in flight during clearing pass");

  a_read_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_rd_q |=> bin_count_valid_o)
    else $error("read request lost its result");

  a_result_has_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bin_count_valid_o |-> $past(s1_rd_q))
    else $error("result without a read request");

  a_sat_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_bump_q && (&cur_cnt) |=> wr_last_data_q == $past(cur_cnt))
    else $error("saturated counter wrapped");
`endif

endmodule
